FILE: rtl/core/kth_pkg.sv
// Shared definitions for the keyed timer heap: operation and status codes,
// stream payload widths and default parameter values. No dependencies.
package kth_pkg;

  localparam int unsigned DefCapacity  = 256;
  localparam int unsigned DefKeyBits   = 32;
  localparam int unsigned DefValueBits = 32;

  localparam int unsigned InDataBits  = 128;
  localparam int unsigned InUserBits  = 3;
  localparam int unsigned OutDataBits = 248;

  typedef enum logic [2:0] {
    KIND_PUSH       = 3'd0,
    KIND_POP        = 3'd1,
    KIND_MOVE_EARLY = 3'd2,
    KIND_RESCHED    = 3'd3,
    KIND_RESCHED_TOP = 3'd4,
    KIND_DELETE     = 3'd5,
    KIND_LOOKUP     = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  // Clamp a count to the nine bits of the result fields.
  function automatic logic [8:0] sat9(input logic [31:0] v);
    sat9 = (v > 32'd511) ? 9'd511 : v[8:0];
  endfunction

endpackage

FILE: rtl/core/keyed_timer_heap.sv
// Keyed timer heap: a binary min-heap of timers held in one single-port
// style memory and worked on by a small sequencer. Depends on kth_pkg.
//
// The block keeps up to CAPACITY timers, each holding a signed 64-bit
// expiry time, a key, a value and an insertion stamp, in a binary min-heap
// ordered by expiry time. One request is taken at a time: s_axis_tready_o
// is high only while the sequencer is idle, and each request gives exactly
// one result, which waits in an output register until it is taken (the
// next request may be taken meanwhile). The heap memory is read at one
// address and written at one address per cycle, with registered read data,
// and that port sets the timing. A push sifts the new timer up from the
// end of the heap; a pop or a top reschedule sifts an entry down from the
// root. Keyed requests (move earlier, reschedule, delete) scan the whole
// heap once per matching timer to find the oldest match still to be
// handled, plus a last scan that finds none; a lookup stops at the oldest
// match. The memory needs no clearing pass after reset: only entries
// below the timer count are ever used, and the top of an empty heap is
// reported as zero.
module keyed_timer_heap
  import kth_pkg::*;
#(
  parameter int unsigned CAPACITY   = DefCapacity,
  parameter int unsigned KEY_BITS   = DefKeyBits,
  parameter int unsigned VALUE_BITS = DefValueBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // expiry_time[63:0], timer_key[95:64], timer_value[127:96]
  input  logic [InDataBits-1:0]  s_axis_tdata_i,
  // kind[2:0]
  input  logic [InUserBits-1:0]  s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // status[1:0], matched_count[10:2], found_time[74:11], found_value[106:75],
  // top_valid[107], top_time[171:108], top_key[203:172], top_value[235:204],
  // timer_count[244:236], zero padding[247:245]
  output logic [OutDataBits-1:0] m_axis_tdata_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW    = AW + 2;

  typedef struct packed {
    logic signed [63:0]    t;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
    logic [31:0]           stamp;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_ROUND, ST_FETCH, ST_FETCH_W, ST_UP_RD, ST_UP_CMP,
    ST_DN_RD1, ST_DN_RD2, ST_DN_CMP, ST_TOP_RD, ST_DONE
  } state_e;

  // Heap memory.
  entry_t mem_q [CAPACITY];
  entry_t rd_q;
  logic   rd_en, we;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t wr_data;

  state_e state_q;
  kind_e  kind_q;
  logic signed [63:0]    t_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [CNT_W-1:0] held_q, cnt_q, idx_q;
  logic [31:0]      stamp_q, thr_q, bage_q;
  entry_t           cur_q, kid_q, bent_q;
  logic [AW-1:0]    pos_q, rpos_q, bpos_q;
  logic             chk_q, first_q, bf_q, dn_after_q, two_q;
  status_e          status_q;
  logic signed [63:0]    ftime_q;
  logic [VALUE_BITS-1:0] fval_q;
  logic                  m_valid_q;
  logic [OutDataBits-1:0] m_data_q;

  // Shared compare and index logic.
  logic [AW-1:0] parent_pos;
  logic [CW-1:0] c_w, c1_w, held_ext;
  logic          has_kid, has_two, up_less, pick2, dn_less, hit;
  entry_t        child_ent;
  logic [AW-1:0] child_pos;
  logic [31:0]   age;
  entry_t        bent_re, rd_re;
  logic          out_load;

  assign parent_pos = AW'((pos_q - 1'b1) >> 1);
  assign c_w        = {1'b0, pos_q, 1'b1};
  assign c1_w       = c_w + 1'b1;
  assign held_ext   = CW'(held_q);
  assign has_kid    = c_w < held_ext;
  assign has_two    = c1_w < held_ext;
  assign up_less    = cur_q.t < rd_q.t;
  assign pick2      = two_q && (rd_q.t < kid_q.t);
  assign child_ent  = pick2 ? rd_q : kid_q;
  assign child_pos  = pick2 ? c1_w[AW-1:0] : c_w[AW-1:0];
  assign dn_less    = child_ent.t < cur_q.t;
  assign age        = stamp_q - rd_q.stamp;
  assign hit        = chk_q && (rd_q.key == key_q) && (first_q || age < thr_q)
                      && (!bf_q || age > bage_q);
  assign out_load   = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready_i);

  // Matched or fetched entry carrying the requested expiry time.
  always_comb begin
    bent_re   = bent_q;
    bent_re.t = t_q;
    rd_re     = rd_q;
    rd_re.t   = t_q;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wr_addr = pos_q;
    wr_data = cur_q;
    case (state_q)
      ST_SCAN: begin
        rd_en   = idx_q < held_q;
        rd_addr = idx_q[AW-1:0];
      end
      ST_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = (kind_q == KIND_RESCHED_TOP) ? '0 : AW'(held_q);
      end
      ST_UP_RD: begin
        if (pos_q == '0) begin
          we = !dn_after_q;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent_pos;
        end
      end
      ST_UP_CMP: begin
        if (up_less) begin
          we      = 1'b1;
          wr_data = rd_q;
        end else begin
          we = !dn_after_q;
        end
      end
      ST_DN_RD1: begin
        if (has_kid) begin
          rd_en   = 1'b1;
          rd_addr = c_w[AW-1:0];
        end else begin
          we = 1'b1;
        end
      end
      ST_DN_RD2: begin
        rd_en   = has_two;
        rd_addr = c1_w[AW-1:0];
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (dn_less) wr_data = child_ent;
      end
      ST_TOP_RD: begin
        rd_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  logic keyed;
  assign keyed = (kind_q == KIND_MOVE_EARLY) || (kind_q == KIND_RESCHED) ||
                 (kind_q == KIND_DELETE) || (kind_q == KIND_LOOKUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      kind_q     <= KIND_PUSH;
      t_q        <= '0;
      key_q      <= '0;
      held_q     <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      stamp_q    <= '0;
      thr_q      <= '0;
      bage_q     <= '0;
      cur_q      <= '0;
      kid_q      <= '0;
      bent_q     <= '0;
      pos_q      <= '0;
      rpos_q     <= '0;
      bpos_q     <= '0;
      chk_q      <= 1'b0;
      first_q    <= 1'b0;
      bf_q       <= 1'b0;
      dn_after_q <= 1'b0;
      two_q      <= 1'b0;
      status_q   <= STATUS_OK;
      ftime_q    <= '0;
      fval_q     <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      if (out_load) m_valid_q <= 1'b1;
      else if (m_valid_q && m_axis_tready_i) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            kind_q     <= kind_e'(s_axis_tuser_i);
            t_q        <= s_axis_tdata_i[63:0];
            key_q      <= KEY_BITS'(s_axis_tdata_i[95:64]);
            ftime_q    <= '0;
            fval_q     <= '0;
            dn_after_q <= 1'b0;
            first_q    <= 1'b1;
            idx_q      <= '0;
            chk_q      <= 1'b0;
            bf_q       <= 1'b0;
            case (kind_e'(s_axis_tuser_i))
              KIND_PUSH: begin
                cnt_q <= '0;
                if (held_q == CNT_W'(CAPACITY)) begin
                  status_q <= STATUS_FULL;
                  state_q  <= ST_TOP_RD;
                end else begin
                  status_q <= STATUS_OK;
                  cur_q <= '{t: s_axis_tdata_i[63:0],
                             key: KEY_BITS'(s_axis_tdata_i[95:64]),
                             val: VALUE_BITS'(s_axis_tdata_i[127:96]),
                             stamp: stamp_q};
                  stamp_q <= stamp_q + 32'd1;
                  pos_q   <= AW'(held_q);
                  held_q  <= held_q + 1'b1;
                  state_q <= ST_UP_RD;
                end
              end
              KIND_POP: begin
                if (held_q == '0) begin
                  status_q <= STATUS_EMPTY;
                  cnt_q    <= '0;
                  state_q  <= ST_TOP_RD;
                end else begin
                  status_q <= STATUS_OK;
                  cnt_q    <= CNT_W'(1);
                  held_q   <= held_q - 1'b1;
                  pos_q    <= '0;
                  state_q  <= (held_q != CNT_W'(1)) ? ST_FETCH : ST_TOP_RD;
                end
              end
              KIND_RESCHED_TOP: begin
                if (held_q == '0) begin
                  status_q <= STATUS_EMPTY;
                  cnt_q    <= '0;
                  state_q  <= ST_TOP_RD;
                end else begin
                  status_q <= STATUS_OK;
                  cnt_q    <= CNT_W'(1);
                  pos_q    <= '0;
                  state_q  <= ST_FETCH;
                end
              end
              KIND_MOVE_EARLY, KIND_RESCHED, KIND_DELETE, KIND_LOOKUP: begin
                status_q <= STATUS_OK;
                cnt_q    <= '0;
                state_q  <= ST_SCAN;
              end
              default: begin
                status_q <= STATUS_OK;
                cnt_q    <= '0;
                state_q  <= ST_TOP_RD;
              end
            endcase
          end
        end

        // Walk the heap, keeping the oldest matching timer younger than the
        // one handled in the previous round.
        ST_SCAN: begin
          if (hit) begin
            bf_q   <= 1'b1;
            bage_q <= age;
            bpos_q <= rpos_q;
            bent_q <= rd_q;
          end
          if (idx_q < held_q) begin
            rpos_q <= idx_q[AW-1:0];
            idx_q  <= idx_q + 1'b1;
            chk_q  <= 1'b1;
          end else begin
            chk_q <= 1'b0;
            if (!chk_q) state_q <= ST_ROUND;
          end
        end

        ST_ROUND: begin
          idx_q <= '0;
          bf_q  <= 1'b0;
          if (!bf_q) begin
            if (first_q) status_q <= STATUS_NOT_FOUND;
            state_q <= ST_TOP_RD;
          end else begin
            first_q <= 1'b0;
            thr_q   <= bage_q;
            pos_q   <= bpos_q;
            case (kind_q)
              KIND_LOOKUP: begin
                ftime_q <= bent_q.t;
                fval_q  <= bent_q.val;
                state_q <= ST_TOP_RD;
              end
              KIND_MOVE_EARLY: begin
                if (bent_q.t <= t_q) begin
                  state_q <= ST_SCAN;
                end else begin
                  cur_q   <= bent_re;
                  cnt_q   <= cnt_q + 1'b1;
                  state_q <= ST_UP_RD;
                end
              end
              KIND_RESCHED: begin
                cur_q   <= bent_re;
                cnt_q   <= cnt_q + 1'b1;
                state_q <= (bent_q.t > t_q) ? ST_UP_RD : ST_DN_RD1;
              end
              default: begin
                // Delete: the last entry fills the hole unless it is the hole.
                cnt_q  <= cnt_q + 1'b1;
                held_q <= held_q - 1'b1;
                if (bpos_q == AW'(held_q - 1'b1)) state_q <= ST_SCAN;
                else state_q <= ST_FETCH;
              end
            endcase
          end
        end

        ST_FETCH: state_q <= ST_FETCH_W;

        ST_FETCH_W: begin
          case (kind_q)
            KIND_DELETE: begin
              cur_q      <= rd_q;
              dn_after_q <= 1'b1;
              state_q    <= ST_UP_RD;
            end
            KIND_RESCHED_TOP: begin
              cur_q   <= rd_re;
              state_q <= ST_DN_RD1;
            end
            default: begin
              cur_q   <= rd_q;
              state_q <= ST_DN_RD1;
            end
          endcase
        end

        ST_UP_RD: begin
          if (pos_q == '0) begin
            if (dn_after_q) begin
              dn_after_q <= 1'b0;
              state_q    <= ST_DN_RD1;
            end else begin
              state_q <= keyed ? ST_SCAN : ST_TOP_RD;
            end
          end else begin
            state_q <= ST_UP_CMP;
          end
        end

        ST_UP_CMP: begin
          if (up_less) begin
            pos_q   <= parent_pos;
            state_q <= ST_UP_RD;
          end else if (dn_after_q) begin
            dn_after_q <= 1'b0;
            state_q    <= ST_DN_RD1;
          end else begin
            state_q <= keyed ? ST_SCAN : ST_TOP_RD;
          end
        end

        ST_DN_RD1: begin
          if (has_kid) state_q <= ST_DN_RD2;
          else state_q <= keyed ? ST_SCAN : ST_TOP_RD;
        end

        ST_DN_RD2: begin
          kid_q   <= rd_q;
          two_q   <= has_two;
          state_q <= ST_DN_CMP;
        end

        ST_DN_CMP: begin
          if (dn_less) begin
            pos_q   <= child_pos;
            state_q <= ST_DN_RD1;
          end else begin
            state_q <= keyed ? ST_SCAN : ST_TOP_RD;
          end
        end

        ST_TOP_RD: state_q <= ST_DONE;

        // Hand the result over once the output register is free.
        ST_DONE: begin
          if (out_load) begin
            m_data_q  <= {3'b000,
                          sat9(32'(held_q)),
                          (held_q != '0) ? 32'(rd_q.val) : 32'd0,
                          (held_q != '0) ? 32'(rd_q.key) : 32'd0,
                          (held_q != '0) ? rd_q.t : 64'sd0,
                          held_q != '0,
                          32'(fval_q),
                          ftime_q,
                          sat9(32'(cnt_q)),
                          status_q};
            state_q   <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

FILE: rtl/core/kth_checker.sv
// Port-level checks for the keyed timer heap, bound to its top level.
// Depends on kth_pkg and keyed_timer_heap.
module kth_checker
  import kth_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OutDataBits-1:0] m_axis_tdata_o
);

  // A taken request leaves the sequencer busy in the following cycle.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while previous one still in progress");

  // An empty heap reports a zeroed top.
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[107] |->
      m_axis_tdata_o[235:108] == '0)
    else $error("top fields not zero on empty heap");

  // The top is valid exactly when timers are held.
  a_count_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[244:236] != '0) == m_axis_tdata_o[107])
    else $error("top valid disagrees with timer count");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

endmodule

bind keyed_timer_heap kth_checker u_kth_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
